/* rtl/isws_pkg.sv */
// Shared types and constants of the insertion sorter with operation counts.
package isws_pkg;

    localparam int VAL_W = 32;
    localparam int CNT_W = 12;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // One input beat.
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } t_in;

    // One result beat.
    typedef struct packed {
        logic signed [VAL_W-1:0] sorted_value;
        logic [CNT_W-1:0]        comparisons;
        logic [CNT_W-1:0]        moves;
        logic                    overflow;
        logic                    final_res;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic insert;
        logic tally;
        logic emit;
        logic clear;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic one_left;
        logic out_free;
    } t_stat;

endpackage

/* rtl/insertion_sort_with_stats_core.sv */
// Top level of the stable insertion sorter with comparison and move counts.
//
//  Channel   Direction  Handshake                 Beat contents
//  -------   ---------  ------------------------  ------------------------------------
//  in        input      i_in_valid / o_in_ready   value to sort, last-of-set flag
//  out       output     o_out_valid / i_out_ready sorted value, counts, overflow, final
//
// Each input beat passes through an insert step, in which every stored cell
// compares itself with the new value and the row shifts to open the slot,
// and a tally step, in which the comparison and move totals are updated from
// the shift count. After the beat marked last, the sorted set leaves at one
// beat per cycle while the sink is ready. Reset is synchronous and active
// low; it empties the store and clears all counts and the output register's
// valid flag. A stalled sink holds the current result beat steady and pauses
// the drain; the input stays closed until the last beat of the set has been
// loaded into the output register.
module insertion_sort_with_stats_core #(
    parameter int DEPTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  isws_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output isws_pkg::t_out o_out
);

    // Command and status bundles between the sequencer and the datapath.
    isws_pkg::t_cmd  w_cmd;
    isws_pkg::t_stat w_stat;

    // The controller walks through accept, tally and drain phases. It raises
    // insert, tally or emit by phase, adding clear where a set ends, and never looks at the data values itself.
    isws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in.last),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the sorted row of cells, the element count, the
    // saturating totals, the overflow flag and the registered result beat.
    // Values arriving with the row full are dropped and only raise overflow.
    isws_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in        (i_in),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

/* rtl/isws_ctrl.sv */
// Controller of the insertion sorter: sequences insert, tally and emit phases.
module isws_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_last,
    output logic           o_in_ready,
    input  isws_pkg::t_stat i_stat,
    output isws_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IN,
        S_TALLY,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_last;

    assign o_in_ready = (r_state == S_IN);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IN: begin
                if (i_in_valid) begin
                    o_cmd.insert = 1'b1;
                    n_state      = S_TALLY;
                end
            end
            S_TALLY: begin
                o_cmd.tally = 1'b1;
                if (r_last) begin
                    if (i_stat.empty) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IN;
                    end else begin
                        n_state = S_EMIT;
                    end
                end else begin
                    n_state = S_IN;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.one_left) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IN;
                    end
                end
            end
            default: n_state = S_IN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.insert) begin
                r_last <= i_in_last;
            end
        end
    end

endmodule

/* rtl/isws_dp.sv */
// Datapath of the insertion sorter: sorted cell row, counters and output register.
module isws_dp #(
    parameter int DEPTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  isws_pkg::t_cmd  i_cmd,
    output isws_pkg::t_stat o_stat,
    input  isws_pkg::t_in   i_in,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output isws_pkg::t_out  o_out
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic signed [isws_pkg::VAL_W-1:0] r_cell [DEPTH];
    logic signed [isws_pkg::VAL_W-1:0] n_cell [DEPTH];
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    logic [isws_pkg::CNT_W-1:0]  r_cmp;
    logic [isws_pkg::CNT_W-1:0]  n_cmp;
    logic [isws_pkg::CNT_W-1:0]  r_mov;
    logic [isws_pkg::CNT_W-1:0]  n_mov;
    logic                        r_drop;
    logic                        n_drop;
    logic [CW-1:0]               r_shift;
    logic                        r_had;
    logic                        r_out_valid;
    isws_pkg::t_out              r_out;

    logic [DEPTH-1:0]            w_le;
    logic [DEPTH-1:0]            w_slot;
    logic [IW-1:0]               w_pos;
    logic [CW-1:0]               w_inc;
    logic [isws_pkg::CNT_W:0]    w_cmp_sum;
    logic [isws_pkg::CNT_W:0]    w_mov_sum;
    logic                        w_full;

    assign w_full = (r_count == CW'(DEPTH));

    // Each stored cell compares itself with the arriving value. Because the
    // row is sorted and occupied from cell 0, the "not greater" flags form a
    // prefix and the insertion slot is the single cell where that prefix ends.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_le[i] = (CW'(i) < r_count) && (r_cell[i] <= i_in.value);
        end
        w_slot[0] = !w_le[0];
        for (int i = 1; i < DEPTH; i++) begin
            w_slot[i] = !w_le[i] && w_le[i-1];
        end
        w_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_slot[i]) begin
                w_pos = w_pos | IW'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_cell[i] = r_cell[i];
        end
        if (i_cmd.insert && !w_full) begin
            n_cell[0] = w_le[0] ? r_cell[0] : i_in.value;
            for (int i = 1; i < DEPTH; i++) begin
                if (w_le[i]) begin
                    n_cell[i] = r_cell[i];
                end else if (w_slot[i]) begin
                    n_cell[i] = i_in.value;
                end else begin
                    n_cell[i] = r_cell[i-1];
                end
            end
        end else if (i_cmd.emit) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                n_cell[i] = r_cell[i+1];
            end
        end
    end

    // Comparisons and moves both grow by the shift count plus one for every
    // element inserted while the row already held another.
    assign w_inc     = r_had ? (r_shift + CW'(1)) : '0;
    assign w_cmp_sum = {1'b0, r_cmp} + (isws_pkg::CNT_W + 1)'(w_inc);
    assign w_mov_sum = {1'b0, r_mov} + (isws_pkg::CNT_W + 1)'(w_inc);

    always_comb begin
        n_count = r_count;
        n_cmp   = r_cmp;
        n_mov   = r_mov;
        n_drop  = r_drop;
        if (i_cmd.insert) begin
            if (w_full) begin
                n_drop = 1'b1;
            end else begin
                n_count = r_count + CW'(1);
            end
        end
        if (i_cmd.tally) begin
            n_cmp = w_cmp_sum[isws_pkg::CNT_W] ? isws_pkg::CNT_MAX
                                               : w_cmp_sum[isws_pkg::CNT_W-1:0];
            n_mov = w_mov_sum[isws_pkg::CNT_W] ? isws_pkg::CNT_MAX
                                               : w_mov_sum[isws_pkg::CNT_W-1:0];
        end
        if (i_cmd.emit) begin
            n_count = r_count - CW'(1);
        end
        if (i_cmd.clear) begin
            n_count = '0;
            n_cmp   = '0;
            n_mov   = '0;
            n_drop  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_cell[i] <= n_cell[i];
        end
        if (i_cmd.insert) begin
            r_shift <= r_count - CW'(w_pos);
            r_had   <= (r_count != '0) && !w_full;
        end
        if (i_cmd.emit) begin
            r_out.sorted_value <= r_cell[0];
            r_out.comparisons  <= r_cmp;
            r_out.moves        <= r_mov;
            r_out.overflow     <= r_drop;
            r_out.final_res    <= (r_count == CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cmp       <= '0;
            r_mov       <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_cmp   <= n_cmp;
            r_mov   <= n_mov;
            r_drop  <= n_drop;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.full     = w_full;
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.one_left = (r_count == CW'(1));
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* rtl/isws_chk.sv */
// Port-level checker for the insertion sorter, bound to the top level.
module isws_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input isws_pkg::t_in  i_in,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input isws_pkg::t_out o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result beat changed while stalled");

    a_closed_while_draining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.final_res |-> !o_in_ready)
        else $error("input open while a set is still draining");

    a_counts_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.comparisons == o_out.moves)
        else $error("comparison and move totals differ");

    a_set_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out.final_res |=>
            o_out_valid && $stable(o_out.comparisons) && $stable(o_out.overflow))
        else $error("drain gap or totals changed within a set");

    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out.final_res |=>
            o_out.sorted_value >= $past(o_out.sorted_value))
        else $error("results out of ascending order");

endmodule

bind insertion_sort_with_stats_core isws_chk u_isws_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
